// ===== hdl/array_list_engine_macros.svh =====
// Assertion helpers shared by the list engine.
`ifndef ARRAY_LIST_ENGINE_MACROS_SVH
`define ARRAY_LIST_ENGINE_MACROS_SVH

// Same-cycle implication, checked at the rising edge, idle while in reset.
`define ALE_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("list engine check failed");

// Next-cycle implication, checked at the rising edge, idle while in reset.
`define ALE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("list engine check failed");

`endif

// ===== hdl/ale_pkg.sv =====
package ale_pkg;

    // Sizing of the stored list
    localparam int CAPACITY    = 32;
    localparam int VALUE_WIDTH = 32;
    localparam int IDX_W       = $clog2(CAPACITY);
    localparam int CNT_W       = $clog2(CAPACITY + 1);

    // Fixed field widths of the streaming ports
    localparam int ACTION_W = 2;
    localparam int POS_W    = 6;
    localparam int VALUE_IN_W = 32;
    localparam int STATUS_W = 2;
    localparam int FOUND_W  = 5;
    localparam int COUNT_W  = 6;

    localparam int S_TDATA_W = ((POS_W + VALUE_IN_W + 7) / 8) * 8;
    localparam int M_TDATA_W = ((FOUND_W + COUNT_W + 7) / 8) * 8;

    // Width wide enough to compare positions against the count
    localparam int CMP_W = ((CNT_W > POS_W) ? CNT_W : POS_W) + 1;

    // Request kinds
    localparam logic [ACTION_W-1:0] ACT_FIND   = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_DELETE = 2'd2;

    // Answer codes
    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_BAD_POS  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NOT_FOUND = 2'd3;

    // Sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SCAN,
        ST_SHIFT,
        ST_PLACE,
        ST_FINISH
    } state_t;

    // Sign-extend the incoming word and keep the stored width.
    function automatic logic [VALUE_WIDTH-1:0] norm_value(input logic signed [VALUE_IN_W-1:0] raw);
        logic signed [63:0] ext;
        ext = 64'(raw);
        return ext[VALUE_WIDTH-1:0];
    endfunction

endpackage

// ===== hdl/array_list_engine.sv =====
// Ordered list engine: holds up to CAPACITY signed words in an internal memory.
// Requests arrive on the slave stream: tuser carries the kind (find, insert,
// delete) and tdata the 1-based position and the value. Each request gives
// exactly one answer transaction on the master stream: tuser carries the status
// and tdata the index of the first match and the entry count after the request.
// The block takes one request at a time; s_axis_tready is high only while the
// sequencer is idle. A find walks the list from index 0, an insert moves the
// entries from the end down to the position up by one place, a delete moves
// the entries after the position down by one place. The memory has one read
// and one write port, so one entry is handled per cycle. A rejected request
// goes straight to the finish state. The next request is accepted in the
// cycle after the answer is loaded.
// The answer sits in an output register, so the next request is accepted while
// an answer waits; if the receiver stalls, a finished request holds in its last
// state until the output register is free, and the input stays closed.
// Reset empties the list (count zero) and drops any pending answer; the memory
// contents are not cleared, since only written entries are ever read.
`include "array_list_engine_macros.svh"

module array_list_engine
    import ale_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [S_TDATA_W-1:0] s_axis_tdata,  // position [5:0], value [37:6], zero fill
    input  logic [ACTION_W-1:0]  s_axis_tuser,  // action [1:0]
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [M_TDATA_W-1:0] m_axis_tdata,  // found_index [4:0], entry_count [10:5], zero fill
    output logic [STATUS_W-1:0]  m_axis_tuser   // status [1:0]
);

    // Sequencer and list state
    state_t                 state_reg, state_next;
    logic [CNT_W-1:0]       count_reg, count_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    logic [IDX_W-1:0]       rd_ptr_reg, rd_ptr_next;
    logic                   pend_reg, pend_next;
    logic [IDX_W-1:0]       pend_addr_reg, pend_addr_next;
    logic                   dir_up_reg, dir_up_next;

    // Request and answer holding registers
    logic [POS_W-1:0]       pos_reg, pos_next;
    logic [VALUE_WIDTH-1:0] val_reg, val_next;
    logic [STATUS_W-1:0]    res_status_reg, res_status_next;
    logic [IDX_W-1:0]       res_idx_reg, res_idx_next;

    // Output register
    logic                   out_valid_reg, out_valid_next;
    logic [STATUS_W-1:0]    out_status_reg, out_status_next;
    logic [FOUND_W-1:0]     out_idx_reg, out_idx_next;
    logic [COUNT_W-1:0]     out_count_reg, out_count_next;

    // Entry memory ports
    logic [VALUE_WIDTH-1:0] mem [CAPACITY];
    logic                   mem_re, mem_we;
    logic [IDX_W-1:0]       mem_raddr, mem_waddr;
    logic [VALUE_WIDTH-1:0] mem_wdata;
    logic [VALUE_WIDTH-1:0] rdata_reg;

    // Request decode
    logic                   s_accept;
    logic [POS_W-1:0]       s_pos;
    logic [VALUE_IN_W-1:0]  s_value;
    logic [CMP_W-1:0]       pos_ext, cnt_ext;
    state_t                 dec_state;
    logic [STATUS_W-1:0]    dec_status;
    logic [CNT_W-1:0]       dec_rem;
    logic [IDX_W-1:0]       dec_rd_ptr;
    logic                   hit, walk_done, out_free;

    assign s_pos     = s_axis_tdata[POS_W-1:0];
    assign s_value   = s_axis_tdata[POS_W+VALUE_IN_W-1:POS_W];
    assign s_accept  = s_axis_tvalid && s_axis_tready;
    assign pos_ext   = CMP_W'(s_pos);
    assign cnt_ext   = CMP_W'(count_reg);
    assign hit       = pend_reg && (rdata_reg == val_reg);
    assign walk_done = (rem_reg == '0) && !pend_reg;
    assign out_free  = !out_valid_reg || m_axis_tready;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tdata  = M_TDATA_W'({out_count_reg, out_idx_reg});

    // Classify an incoming request and set up its walk over the memory.
    always_comb
    begin
        dec_state  = ST_FINISH;
        dec_status = STATUS_OK;
        dec_rem    = '0;
        dec_rd_ptr = '0;
        case (s_axis_tuser)
            ACT_FIND:
            begin
                dec_rem = count_reg;
                if (count_reg == '0)
                begin
                    dec_status = STATUS_NOT_FOUND;
                end
                else
                begin
                    dec_state = ST_SCAN;
                end
            end
            ACT_INSERT:
            begin
                if (count_reg >= CNT_W'(CAPACITY))
                begin
                    dec_status = STATUS_FULL;
                end
                else if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1))
                begin
                    dec_status = STATUS_BAD_POS;
                end
                else
                begin
                    dec_state  = ST_SHIFT;
                    dec_rem    = CNT_W'(cnt_ext - pos_ext + CMP_W'(1));
                    dec_rd_ptr = IDX_W'(cnt_ext - CMP_W'(1));
                end
            end
            ACT_DELETE:
            begin
                if (pos_ext == '0 || pos_ext > cnt_ext)
                begin
                    dec_status = STATUS_BAD_POS;
                end
                else
                begin
                    dec_state  = ST_SHIFT;
                    dec_rem    = CNT_W'(cnt_ext - pos_ext);
                    dec_rd_ptr = IDX_W'(pos_ext);
                end
            end
            default:
            begin
                dec_status = STATUS_BAD_POS;
            end
        endcase
    end

    // Next state of the sequencer
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    state_next = dec_state;
                end
            end
            ST_SCAN:
            begin
                if (hit || walk_done)
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_SHIFT:
            begin
                if (walk_done)
                begin
                    state_next = dir_up_reg ? ST_PLACE : ST_FINISH;
                end
            end
            ST_PLACE:
            begin
                state_next = ST_FINISH;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Datapath controls and register updates for each state
    always_comb
    begin
        count_next      = count_reg;
        rem_next        = rem_reg;
        rd_ptr_next     = rd_ptr_reg;
        pend_next       = 1'b0;
        pend_addr_next  = pend_addr_reg;
        dir_up_next     = dir_up_reg;
        pos_next        = pos_reg;
        val_next        = val_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        out_valid_next  = out_valid_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_idx_next    = out_idx_reg;
        out_count_next  = out_count_reg;
        mem_re          = 1'b0;
        mem_raddr       = rd_ptr_reg;
        mem_we          = 1'b0;
        mem_waddr       = dir_up_reg ? pend_addr_reg + IDX_W'(1) : pend_addr_reg - IDX_W'(1);
        mem_wdata       = rdata_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (s_accept)
                begin
                    pos_next        = s_pos;
                    val_next        = norm_value(s_value);
                    res_status_next = dec_status;
                    res_idx_next    = '0;
                    rem_next        = dec_rem;
                    rd_ptr_next     = dec_rd_ptr;
                    dir_up_next     = (s_axis_tuser == ACT_INSERT);
                end
            end
            ST_SCAN:
            begin
                // Read one entry per cycle; compare the one read in the cycle before.
                if (hit)
                begin
                    res_idx_next = pend_addr_reg;
                end
                else if (walk_done)
                begin
                    res_status_next = STATUS_NOT_FOUND;
                end
                else if (rem_reg != '0)
                begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = rd_ptr_reg;
                    rd_ptr_next    = rd_ptr_reg + IDX_W'(1);
                    rem_next       = rem_reg - CNT_W'(1);
                end
            end
            ST_SHIFT:
            begin
                // Move the entry read in the cycle before one place along.
                mem_we = pend_reg;
                if (rem_reg != '0)
                begin
                    mem_re         = 1'b1;
                    pend_next      = 1'b1;
                    pend_addr_next = rd_ptr_reg;
                    rd_ptr_next    = dir_up_reg ? rd_ptr_reg - IDX_W'(1)
                                                : rd_ptr_reg + IDX_W'(1);
                    rem_next       = rem_reg - CNT_W'(1);
                end
                else if (!pend_reg && !dir_up_reg)
                begin
                    count_next = count_reg - CNT_W'(1);
                end
            end
            ST_PLACE:
            begin
                // The gap is open: store the new value there.
                mem_we     = 1'b1;
                mem_waddr  = IDX_W'(pos_reg - POS_W'(1));
                mem_wdata  = val_reg;
                count_next = count_reg + CNT_W'(1);
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_idx_next    = FOUND_W'(res_idx_reg);
                    out_count_next  = COUNT_W'(count_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            count_reg     <= '0;
            rem_reg       <= '0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            rem_reg       <= rem_next;
            pend_reg      <= pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        rd_ptr_reg     <= rd_ptr_next;
        pend_addr_reg  <= pend_addr_next;
        dir_up_reg     <= dir_up_next;
        pos_reg        <= pos_next;
        val_reg        <= val_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        out_status_reg <= out_status_next;
        out_idx_reg    <= out_idx_next;
        out_count_reg  <= out_count_next;
    end

    // Entry memory with registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (mem_re)
        begin
            rdata_reg <= mem[mem_raddr];
        end
    end

    // Checks on the sequencer and the list state
    `ALE_ASSERT_IMPL(a_count_in_range, clk, rst_n, 1'b1, count_reg <= CNT_W'(CAPACITY))
    `ALE_ASSERT_NEXT(a_accept_leaves_idle, clk, rst_n, s_accept, state_reg != ST_IDLE)
    `ALE_ASSERT_NEXT(a_finish_loads_output, clk, rst_n, state_reg == ST_FINISH && out_free, m_axis_tvalid)
    `ALE_ASSERT_IMPL(a_find_no_write, clk, rst_n, state_reg == ST_SCAN, !mem_we)

endmodule

// ===== sim/array_list_engine_tb.sv =====
`timescale 1ns / 1ps

module array_list_engine_tb;

    import ale_pkg::*;

    // The one action code that the block does not define.
    localparam logic [ACTION_W-1:0] ACT_UNUSED = 2'd3;

    localparam logic [VALUE_IN_W-1:0] VALUE_MIN = 32'h8000_0000;
    localparam logic [VALUE_IN_W-1:0] VALUE_MAX = 32'h7FFF_FFFF;

    localparam int RANDOM_ITEMS   = 1230;
    localparam int IDLE_PCT       = 9;
    localparam int QUIET_FROM     = 500;
    localparam int QUIET_TO       = 800;
    localparam int DRAIN_CYCLES   = 2 * (CAPACITY + 4);
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int REPORT_LIMIT   = 10;

    typedef logic [CAPACITY-1:0][VALUE_WIDTH-1:0] words_t;

    typedef struct packed {
        words_t     words;
        logic [7:0] count;
    } list_t;

    typedef struct packed {
        logic [ACTION_W-1:0]   action;
        logic [POS_W-1:0]      position;
        logic [VALUE_IN_W-1:0] value;
    } request_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [FOUND_W-1:0]  found_index;
        logic [COUNT_W-1:0]  entry_count;
    } reply_t;

    logic                 clk;
    logic                 rst_n         = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [S_TDATA_W-1:0] s_axis_tdata  = '0;  // position [5:0], value [37:6], zero fill
    logic [ACTION_W-1:0]  s_axis_tuser  = '0;  // action [1:0]
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0] m_axis_tdata;        // found_index [4:0], entry_count [10:5], zero fill
    logic [STATUS_W-1:0]  m_axis_tuser;        // status [1:0]

    request_t request_queue[$];
    reply_t   reply_queue[$];
    request_t in_flight;
    list_t    plan_list;
    list_t    model_list;
    list_t    next_list;

    int sent_count    = 0;
    int checked_count = 0;
    int fail_count    = 0;
    int stall_cycles  = 0;
    int status_hits[4];

    array_list_engine dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // Applies one request to a list and returns the reply that it earns.
    function automatic reply_t serve_request(input list_t cur, input request_t rq,
                                             output list_t nxt);
        reply_t                 rep;
        int                     n;
        int                     p;
        logic [63:0]            wide;
        logic [VALUE_WIDTH-1:0] word;
        nxt  = cur;
        n    = int'(cur.count);
        p    = int'(rq.position);
        wide = {{(64 - VALUE_IN_W){rq.value[VALUE_IN_W-1]}}, rq.value};
        word = wide[VALUE_WIDTH-1:0];
        rep.status      = STATUS_OK;
        rep.found_index = '0;
        case (rq.action)
            ACT_FIND:
            begin
                // Walk from the end so that the lowest matching index wins.
                rep.status = STATUS_NOT_FOUND;
                for (int k = n - 1; k >= 0; k--)
                begin
                    if (cur.words[k] == word)
                    begin
                        rep.status      = STATUS_OK;
                        rep.found_index = FOUND_W'(k);
                    end
                end
            end
            ACT_INSERT:
            begin
                if (n >= CAPACITY)
                    rep.status = STATUS_FULL;
                else if (p < 1 || p > n + 1)
                    rep.status = STATUS_BAD_POS;
                else
                begin
                    for (int k = n; k >= p; k--)
                        nxt.words[k] = cur.words[k-1];
                    nxt.words[p-1] = word;
                    nxt.count      = 8'(n + 1);
                end
            end
            ACT_DELETE:
            begin
                if (p < 1 || p > n)
                    rep.status = STATUS_BAD_POS;
                else
                begin
                    for (int k = p - 1; k < n - 1; k++)
                        nxt.words[k] = cur.words[k+1];
                    nxt.count = 8'(n - 1);
                end
            end
            default:
                rep.status = STATUS_BAD_POS;
        endcase
        rep.entry_count = COUNT_W'(nxt.count);
        return rep;
    endfunction

    // Queues a request and tracks the list that it will leave behind.
    task automatic queue_request(input logic [ACTION_W-1:0] action, input int position,
                                 input logic [VALUE_IN_W-1:0] value);
        request_t rq;
        reply_t   unused_reply;
        list_t    after;
        rq.action    = action;
        rq.position  = POS_W'(position);
        rq.value     = value;
        unused_reply = serve_request(plan_list, rq, after);
        plan_list    = after;
        request_queue.push_back(rq);
    endtask

    // Values drawn half of the time from a narrow range so that duplicates and find hits are common.
    function automatic logic [VALUE_IN_W-1:0] random_value();
        int roll;
        roll = $urandom_range(0, 9);
        if (roll < 5)
            return VALUE_IN_W'($urandom_range(0, 15));
        else if (roll == 5)
        begin
            case ($urandom_range(0, 3))
                0:       return VALUE_MIN;
                1:       return VALUE_MAX;
                2:       return '0;
                default: return '1;
            endcase
        end
        return $urandom;
    endfunction

    // A position outside the valid range, given the lowest invalid one above it.
    function automatic int bad_position(input int lowest_bad);
        int roll;
        roll = $urandom_range(0, 3);
        if (roll == 0)
            return 0;
        else if (roll < 3 && lowest_bad <= 33)
            return $urandom_range(lowest_bad, 33);
        return $urandom_range(34, 63);
    endfunction

    // Stimulus and end of run.
    initial
    begin
        int random_items;
        int phase;
        int span;
        int roll;
        int n;
        random_items    = 0;
        plan_list       = '0;
        model_list      = '0;
        status_hits     = '{default: 0};

        // Directed part: empty list, edges of the position range, extremes of the value.
        queue_request(ACT_FIND,   63, 32'd5);
        queue_request(ACT_DELETE, 1,  32'd0);
        queue_request(ACT_INSERT, 0,  32'd7);
        queue_request(ACT_INSERT, 2,  32'd7);
        queue_request(ACT_INSERT, 1,  VALUE_MIN);
        queue_request(ACT_INSERT, 2,  VALUE_MAX);
        queue_request(ACT_INSERT, 1,  32'd0);
        queue_request(ACT_INSERT, 2,  '1);
        queue_request(ACT_INSERT, 3,  '1);
        queue_request(ACT_INSERT, 7,  32'd9);
        queue_request(ACT_FIND,   0,  VALUE_MAX);
        queue_request(ACT_FIND,   33, VALUE_MIN);
        queue_request(ACT_FIND,   1,  '1);
        queue_request(ACT_FIND,   32, 32'd0);
        queue_request(ACT_FIND,   2,  32'd12345);
        queue_request(ACT_DELETE, 6,  32'd0);
        queue_request(ACT_DELETE, 0,  32'd0);
        queue_request(ACT_DELETE, 33, 32'd0);
        queue_request(ACT_UNUSED, 1,  32'd3);
        queue_request(ACT_DELETE, 5,  32'd0);
        queue_request(ACT_DELETE, 1,  32'd0);
        queue_request(ACT_DELETE, 2,  32'd0);
        queue_request(ACT_FIND,   0,  '1);
        queue_request(ACT_DELETE, 1,  32'd0);

        // Random part in phases that grow, shrink or churn the list.
        while (random_items < RANDOM_ITEMS)
        begin
            phase = $urandom_range(0, 2);
            span  = $urandom_range(20, 80);
            for (int j = 0; j < span; j++)
            begin
                n    = int'(plan_list.count);
                roll = $urandom_range(0, 99);
                if (roll == 99)
                    queue_request(ACT_UNUSED, $urandom_range(0, 63), random_value());
                else if ((phase == 0 && roll < 70) || (phase == 1 && roll < 20) ||
                         (phase == 2 && roll < 35))
                begin
                    if ($urandom_range(0, 99) < 88)
                        queue_request(ACT_INSERT, $urandom_range(1, n + 1), random_value());
                    else
                        queue_request(ACT_INSERT, bad_position(n + 2), random_value());
                end
                else if ((phase == 0 && roll < 85) || (phase == 1 && roll < 35) ||
                         (phase == 2 && roll < 65))
                begin
                    if (n > 0 && $urandom_range(0, 99) < 60)
                        queue_request(ACT_FIND, $urandom_range(0, 63),
                                      plan_list.words[$urandom_range(0, n - 1)]);
                    else
                        queue_request(ACT_FIND, $urandom_range(0, 63), random_value());
                end
                else
                begin
                    if (n > 0 && $urandom_range(0, 99) < 88)
                        queue_request(ACT_DELETE, $urandom_range(1, n), random_value());
                    else
                        queue_request(ACT_DELETE, bad_position(n + 1), random_value());
                end
                random_items++;
            end
        end

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // Wait until every request has gone in and every reply has come back.
        @(negedge clk);
        while (request_queue.size() != 0 || s_axis_tvalid || reply_queue.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        fail_count += reply_queue.size();
        $display("Sent %0d requests and checked %0d replies.", sent_count, checked_count);
        $display("Replies seen: ok %0d, full %0d, bad position %0d, not found %0d.",
                 status_hits[STATUS_OK], status_hits[STATUS_FULL],
                 status_hits[STATUS_BAD_POS], status_hits[STATUS_NOT_FOUND]);
        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Request driver: predicts each accepted transaction and offers the next one.
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= '0;
            s_axis_tuser  <= '0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
            begin
                reply_queue.push_back(serve_request(model_list, in_flight, next_list));
                model_list = next_list;
                sent_count++;
            end
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (request_queue.size() != 0 &&
                    ((sent_count >= QUIET_FROM && sent_count < QUIET_TO) ||
                     $urandom_range(0, 99) >= IDLE_PCT))
                begin
                    in_flight = request_queue.pop_front();
                    s_axis_tvalid <= 1'b1;
                    s_axis_tdata  <= S_TDATA_W'({in_flight.value, in_flight.position});
                    s_axis_tuser  <= in_flight.action;
                end
                else
                    s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Reply monitor: compares each accepted transaction with the oldest prediction.
    always @(posedge clk or negedge rst_n)
    begin
        reply_t got;
        reply_t want;
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                got.status      = m_axis_tuser;
                got.found_index = m_axis_tdata[FOUND_W-1:0];
                got.entry_count = m_axis_tdata[FOUND_W +: COUNT_W];
                checked_count++;
                if (reply_queue.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= REPORT_LIMIT)
                        $display("Unexpected reply: status %0d index %0d count %0d",
                                 got.status, got.found_index, got.entry_count);
                end
                else
                begin
                    want = reply_queue.pop_front();
                    status_hits[want.status]++;
                    if (got.status !== want.status || got.found_index !== want.found_index ||
                        got.entry_count !== want.entry_count)
                    begin
                        fail_count++;
                        if (fail_count <= REPORT_LIMIT)
                            $display("Reply %0d mismatch: status %0d/%0d index %0d/%0d count %0d/%0d (expected/actual)",
                                     checked_count, want.status, got.status, want.found_index,
                                     got.found_index, want.entry_count, got.entry_count);
                    end
                end
            end
            m_axis_tready <= (checked_count >= QUIET_FROM && checked_count < QUIET_TO) ||
                             ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    // Watchdog: ends the run if neither side moves for too long.
    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else
            stall_cycles <= stall_cycles + 1;
        if (stall_cycles >= WATCHDOG_LIMIT)
        begin
            $display("Watchdog expired after %0d idle cycles.", stall_cycles);
            $display("FAILURE");
            $finish;
        end
    end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/ale_pkg.sv
hdl/array_list_engine.sv
sim/array_list_engine_tb.sv
